FILE: rtl/core/dvr_pkg.sv
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared types and constants for the distance-vector route engine: message
// codes, register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package dvr_pkg;

    localparam logic [23:0] INF_DIST = 24'd11451419;
    localparam int          OUT_MAX  = 16;

    typedef enum logic [2:0] {
        FUNC_ENTRY   = 3'd0,
        FUNC_REQUEST = 3'd1,
        FUNC_COST    = 3'd2,
        FUNC_DOWN    = 3'd3,
        FUNC_TRIGGER = 3'd4
    } func_t;

    typedef enum logic [0:0] {
        REG_SELF_ID        = 1'b0,
        REG_ACTIVE_ROUTERS = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_REJECT,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;       // ready for a new request
        logic load;         // capture accepted request
        logic clear_step;   // write one neighbor table entry to infinity
        logic entry_wr;     // store vector entry, learn neighbor
        logic cost_set;     // update port cost
        logic port_down;    // drop port cost and neighbor
        logic rc_init;      // start recompute at first destination
        logic scan_issue;   // read next port's neighbor distance
        logic rc_write;     // commit best route for current destination
        logic emit_init;    // start advertising at first destination
        logic out_load_vec; // load one advertised entry
        logic out_load_rej; // load the reject transaction
    } dvr_cmd_t;

    typedef struct packed {
        func_t func;
        logic  last;
        logic  port_ok;
        logic  reject;
        logic  clear_done;
        logic  n_zero;
        logic  ne_zero;
        logic  scan_last;
        logic  dest_last;
        logic  changed;
        logic  emit_last;
        logic  out_free;
    } dvr_status_t;

endpackage

FILE: rtl/core/dvr_if.sv
// ----------------------------------------------------------------------------
// dvr_req_if / dvr_rsp_if
// Valid/ready channels carrying route messages in and advertised entries out.
// ----------------------------------------------------------------------------
interface dvr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [4:0]  port;
    logic [4:0]  from_router;
    logic [4:0]  dest;
    logic [23:0] distance;
    logic [4:0]  via_router;
    logic        last;

    modport source (output valid, func, port, from_router, dest, distance, via_router, last,
                    input ready);
    modport sink   (input valid, func, port, from_router, dest, distance, via_router, last,
                    output ready);
endinterface

interface dvr_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [4:0]  dest_res;
    logic [23:0] own_distance;
    logic [4:0]  hop_router;
    logic        last_res;

    modport source (output valid, status, dest_res, own_distance, hop_router, last_res,
                    input ready);
    modport sink   (input valid, status, dest_res, own_distance, hop_router, last_res,
                    output ready);
endinterface

FILE: rtl/core/dvr_ram.sv
// ----------------------------------------------------------------------------
// dvr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dvr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/dvr_ctrl.sv
// ----------------------------------------------------------------------------
// dvr_ctrl
// Sequencer: table clear after reset, message decode, recompute scan over
// destinations and ports, and vector advertisement.
// ----------------------------------------------------------------------------
module dvr_ctrl import dvr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  dvr_status_t status,
    output dvr_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   emit_all_reg, emit_all_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            emit_all_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            emit_all_reg <= emit_all_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        emit_all_next = emit_all_reg;
        cmd           = '0;
        req_ready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                case (status.func)
                    FUNC_ENTRY:
                    begin
                        if (status.reject)
                        begin
                            state_next = ST_REJECT;
                        end
                        else
                        begin
                            cmd.entry_wr = 1'b1;
                            if (status.last && !status.n_zero)
                            begin
                                cmd.rc_init   = 1'b1;
                                emit_all_next = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                    end
                    FUNC_REQUEST:
                    begin
                        if (status.reject)
                        begin
                            state_next = ST_REJECT;
                        end
                        else if (!status.ne_zero)
                        begin
                            cmd.emit_init = 1'b1;
                            state_next    = ST_EMIT;
                        end
                    end
                    FUNC_COST, FUNC_DOWN:
                    begin
                        if (status.port_ok)
                        begin
                            cmd.cost_set  = (status.func == FUNC_COST);
                            cmd.port_down = (status.func == FUNC_DOWN);
                            if (!status.n_zero)
                            begin
                                cmd.rc_init   = 1'b1;
                                emit_all_next = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                    end
                    FUNC_TRIGGER:
                    begin
                        if (!status.ne_zero)
                        begin
                            cmd.emit_init = 1'b1;
                            state_next    = ST_EMIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_REJECT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load_rej = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.rc_write = 1'b1;
                if (!status.dest_last)
                begin
                    state_next = ST_SCAN;
                end
                else if ((emit_all_reg || status.changed) && !status.ne_zero)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load_vec = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_load_outside_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("request captured outside idle");
    a_write_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rc_write |-> $past(state_reg) == ST_DRAIN)
        else $error("route commit without completed scan");
    a_single_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load_vec && cmd.out_load_rej))
        else $error("two output loads in one cycle");
`endif

endmodule

FILE: rtl/core/dvr_dp.sv
// ----------------------------------------------------------------------------
// dvr_dp
// Datapath: configuration, port and route tables, neighbor distance RAM,
// minimum search over ports and the output register.
// ----------------------------------------------------------------------------
module dvr_dp import dvr_pkg::*; #(
    parameter int MAX_ROUTERS = 16,
    parameter int MAX_PORTS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dvr_req_if.sink     req,
    dvr_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [4:0]  cfg_data,
    input  dvr_cmd_t    cmd,
    output dvr_status_t status
);

    localparam int RW    = $clog2(MAX_ROUTERS);
    localparam int PW    = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int PNW   = $clog2(MAX_PORTS + 1);
    localparam int DEPTH = MAX_ROUTERS * MAX_ROUTERS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [6:0]    MR7    = 7'(MAX_ROUTERS);
    localparam logic [6:0]    MP7    = 7'(MAX_PORTS);
    localparam logic [6:0]    OUT7   = 7'(OUT_MAX);
    localparam logic [AW-1:0] MR_A   = AW'(MAX_ROUTERS);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
    localparam logic [PW-1:0] LAST_P = PW'(MAX_PORTS - 1);

    // configuration
    logic [4:0] self_id_reg;
    logic [4:0] active_reg;

    // captured request
    func_t       func_reg;
    logic [4:0]  port_reg, from_reg, dest_reg, via_reg;
    logic [23:0] dist_reg;
    logic        last_reg;

    // tables
    logic [23:0]    own_vec_reg   [MAX_ROUTERS];
    logic [PNW-1:0] route_reg     [MAX_ROUTERS];
    logic [23:0]    port_cost_reg [MAX_PORTS];
    logic [4:0]     port_nb_reg   [MAX_PORTS];

    // sequencing
    logic [AW-1:0]  clr_reg;
    logic [RW-1:0]  d_reg;
    logic [PW-1:0]  p_reg;
    logic [RW-1:0]  e_reg;
    logic           pv_reg;
    logic [PW-1:0]  pp_reg;
    logic [23:0]    pcost_reg;
    logic [23:0]    best_reg;
    logic [PNW-1:0] bp_reg;
    logic           changed_reg;

    // output register
    logic        out_valid_reg;
    logic        out_status_reg;
    logic [4:0]  out_dest_reg;
    logic [23:0] out_dist_reg;
    logic [4:0]  out_next_reg;
    logic        out_last_reg;

    logic [6:0]    n_lim, ne_lim;
    logic          port_ok, from_ok, dest_ok;
    logic [PW-1:0] port_idx;
    logic [AW-1:0] waddr, raddr;
    logic          ram_we;
    logic [23:0]   wdata, rdata, dist_sat;
    logic [4:0]    scan_nb;
    logic          scan_nb_ok;
    logic [24:0]   sum;
    logic          better;
    logic          d_is_self;
    logic [23:0]   fin_best;
    logic [PNW-1:0] fin_bp;
    logic          cur_diff;
    logic [PNW-1:0] emit_rp;
    logic [4:0]    emit_nx;
    logic          out_free;

    assign n_lim  = ({2'b0, active_reg} > MR7) ? MR7 : {2'b0, active_reg};
    assign ne_lim = (n_lim > OUT7) ? OUT7 : n_lim;

    assign port_ok  = (port_reg != 5'd0) && ({2'b0, port_reg} <= MP7);
    assign from_ok  = (from_reg != 5'd0) && ({2'b0, from_reg} <= MR7);
    assign dest_ok  = (dest_reg != 5'd0) && ({2'b0, dest_reg} <= MR7);
    assign port_idx = PW'(port_reg - 5'd1);
    assign dist_sat = (dist_reg > INF_DIST) ? INF_DIST : dist_reg;

    assign scan_nb    = port_nb_reg[p_reg];
    assign scan_nb_ok = (scan_nb != 5'd0) && ({2'b0, scan_nb} <= MR7);

    // neighbor table address: neighbor row, destination column
    assign raddr  = AW'(RW'(scan_nb - 5'd1)) * MR_A + AW'(d_reg);
    assign ram_we = cmd.clear_step || (cmd.entry_wr && from_ok && dest_ok);
    assign waddr  = cmd.clear_step ? clr_reg
                  : AW'(RW'(from_reg - 5'd1)) * MR_A + AW'(RW'(dest_reg - 5'd1));
    assign wdata  = (cmd.clear_step || via_reg == self_id_reg) ? INF_DIST : dist_sat;

    dvr_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_nbr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sum    = {1'b0, pcost_reg} + {1'b0, rdata};
    assign better = pv_reg && (sum < {1'b0, best_reg});

    assign d_is_self = ({2'b0, self_id_reg} == 7'(d_reg) + 7'd1);
    assign fin_best  = d_is_self ? 24'd0 : best_reg;
    assign fin_bp    = d_is_self ? '0 : bp_reg;
    assign cur_diff  = (own_vec_reg[d_reg] != fin_best) || (route_reg[d_reg] != fin_bp);

    assign emit_rp = route_reg[e_reg];
    assign emit_nx = (emit_rp != '0) ? port_nb_reg[PW'(emit_rp - PNW'(1))] : 5'd0;

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        status            = '0;
        status.func       = func_reg;
        status.last       = last_reg;
        status.port_ok    = port_ok;
        status.reject     = !port_ok || (port_cost_reg[port_idx] == 24'd0);
        status.clear_done = (clr_reg == LAST_A);
        status.n_zero     = (n_lim == 7'd0);
        status.ne_zero    = (ne_lim == 7'd0);
        status.scan_last  = (p_reg == LAST_P);
        status.dest_last  = (7'(d_reg) + 7'd1 == n_lim);
        status.changed    = changed_reg || cur_diff;
        status.emit_last  = (7'(e_reg) + 7'd1 == ne_lim);
        status.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg <= 5'd1;
            active_reg  <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_SELF_ID:        self_id_reg <= cfg_data;
                REG_ACTIVE_ROUTERS: active_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(req.func);
            port_reg <= req.port;
            from_reg <= req.from_router;
            dest_reg <= req.dest;
            dist_reg <= req.distance;
            via_reg  <= req.via_router;
            last_reg <= req.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROUTERS; i++)
            begin
                own_vec_reg[i] <= (i == 0) ? 24'd0 : INF_DIST;
                route_reg[i]   <= '0;
            end
            for (int i = 0; i < MAX_PORTS; i++)
            begin
                port_cost_reg[i] <= INF_DIST;
                port_nb_reg[i]   <= 5'd0;
            end
        end
        else
        begin
            if (cmd.entry_wr && from_ok && port_nb_reg[port_idx] == 5'd0)
            begin
                port_nb_reg[port_idx] <= from_reg;
            end
            if (cmd.cost_set)
            begin
                port_cost_reg[port_idx] <= dist_sat;
            end
            if (cmd.port_down)
            begin
                port_cost_reg[port_idx] <= INF_DIST;
                port_nb_reg[port_idx]   <= 5'd0;
            end
            if (cmd.rc_write)
            begin
                own_vec_reg[d_reg] <= fin_best;
                route_reg[d_reg]   <= fin_bp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            d_reg       <= '0;
            p_reg       <= '0;
            e_reg       <= '0;
            pv_reg      <= 1'b0;
            best_reg    <= INF_DIST;
            bp_reg      <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            pv_reg <= cmd.scan_issue && scan_nb_ok;
            if (cmd.scan_issue)
            begin
                p_reg <= (p_reg == LAST_P) ? '0 : p_reg + PW'(1);
            end
            if (better)
            begin
                best_reg <= sum[23:0];
                bp_reg   <= PNW'(pp_reg) + PNW'(1);
            end
            if (cmd.rc_init)
            begin
                d_reg       <= '0;
                p_reg       <= '0;
                best_reg    <= INF_DIST;
                bp_reg      <= '0;
                changed_reg <= 1'b0;
            end
            if (cmd.rc_write)
            begin
                d_reg       <= d_reg + RW'(1);
                best_reg    <= INF_DIST;
                bp_reg      <= '0;
                changed_reg <= changed_reg || cur_diff;
            end
            if (cmd.emit_init)
            begin
                e_reg <= '0;
            end
            else if (cmd.out_load_vec)
            begin
                e_reg <= e_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            pp_reg    <= p_reg;
            pcost_reg <= port_cost_reg[p_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load_vec || cmd.out_load_rej)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load_vec)
        begin
            out_status_reg <= 1'b0;
            out_dest_reg   <= 5'(e_reg) + 5'd1;
            out_dist_reg   <= own_vec_reg[e_reg];
            out_next_reg   <= emit_nx;
            out_last_reg   <= (7'(e_reg) + 7'd1 == ne_lim);
        end
        else if (cmd.out_load_rej)
        begin
            out_status_reg <= 1'b1;
            out_dest_reg   <= 5'd0;
            out_dist_reg   <= 24'd0;
            out_next_reg   <= 5'd0;
            out_last_reg   <= 1'b1;
        end
    end

    assign req.ready        = cmd.accept;
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.dest_res     = out_dest_reg;
    assign rsp.own_distance = out_dist_reg;
    assign rsp.hop_router   = out_next_reg;
    assign rsp.last_res     = out_last_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !(cmd.out_load_vec || cmd.out_load_rej))
        else $error("output register overwritten while stalled");
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !(cmd.entry_wr || cmd.load))
        else $error("table access during clear");
    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg <= INF_DIST)
        else $error("best distance beyond infinity");
`endif

endmodule

FILE: rtl/core/distance_vector_route_engine.sv
// ----------------------------------------------------------------------------
// distance_vector_route_engine
// Distance-vector router core with poison reverse.
//
// Usage: route messages enter on req (valid/ready); advertised entries and
// reject notices leave on rsp, one transaction per destination, last_res set
// on the final one. The user writes registers self_id (index 0) and
// active_routers (index 1) on the cfg port only while the block is idle; the
// block itself does not enforce this. Reset clears the tables and then sweeps
// all MAX_ROUTERS*MAX_ROUTERS entries of the neighbor distance RAM to infinity,
// with req.ready held low. One message is processed at a time. A recompute
// walks each destination over every port through the neighbor RAM read port.
// Advertising loads one entry per cycle while the output register is free, up
// to 16 entries. A stalled receiver holds the output register and the sequencer
// waits on it; req.ready returns once the last entry is loaded.
// ----------------------------------------------------------------------------
module distance_vector_route_engine import dvr_pkg::*; #(
    parameter int MAX_ROUTERS = 16,
    parameter int MAX_PORTS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    dvr_req_if.sink    req,
    dvr_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic [0:0] cfg_idx,
    input  logic [4:0] cfg_data
);

    dvr_cmd_t    cmd;
    dvr_status_t status;
    logic        ctrl_ready;

    dvr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctrl_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dvr_dp #(
        .MAX_ROUTERS (MAX_ROUTERS),
        .MAX_PORTS   (MAX_PORTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );

`ifndef ASSERT_OFF
    a_ready_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && ctrl_ready) |-> cmd.load)
        else $error("accepted request not captured");
`endif

endmodule

FILE: tb/dvr_route_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dvr_route_checker
// Watches the message and advertisement channels of the route engine, keeps
// its own copy of the routing tables, predicts every advertised entry and
// reject notice, and compares each response transaction field by field.
// ----------------------------------------------------------------------------
module dvr_route_checker import dvr_pkg::*; #(
    parameter int MAX_ROUTERS = 16,
    parameter int MAX_PORTS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    dvr_req_if         req,
    dvr_rsp_if         rsp,
    input  logic       cfg_we,
    input  logic [0:0] cfg_idx,
    input  logic [4:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    typedef struct {
        logic        status;
        logic [4:0]  dest_res;
        logic [23:0] own_distance;
        logic [4:0]  hop_router;
        logic        last_res;
    } advert_t;

    advert_t     adverts_due[$];
    logic [4:0]  self_id;
    logic [4:0]  active_routers;
    logic [23:0] own_dist   [1:MAX_ROUTERS];
    logic [4:0]  route_port [1:MAX_ROUTERS];
    logic [23:0] nbr_dist   [1:MAX_ROUTERS][1:MAX_ROUTERS];
    logic [23:0] port_cost  [1:MAX_PORTS];
    logic [4:0]  port_nbr   [1:MAX_PORTS];

    function automatic int dest_count();
        return (active_routers > MAX_ROUTERS) ? MAX_ROUTERS : int'(active_routers);
    endfunction

    function automatic void clear_tables();
        self_id        = 5'd1;
        active_routers = 5'd16;
        for (int d = 1; d <= MAX_ROUTERS; d++)
        begin
            own_dist[d]   = (d == 1) ? 24'd0 : INF_DIST;
            route_port[d] = '0;
            for (int s = 1; s <= MAX_ROUTERS; s++)
                nbr_dist[s][d] = INF_DIST;
        end
        for (int p = 1; p <= MAX_PORTS; p++)
        begin
            port_cost[p] = INF_DIST;
            port_nbr[p]  = '0;
        end
    endfunction

    // Minimum over ports of cost plus neighbor distance; first port wins ties.
    function automatic bit update_routes();
        bit          changed;
        logic [24:0] best;
        logic [24:0] sum;
        logic [4:0]  best_port;
        logic [4:0]  nb;
        changed = 1'b0;
        for (int d = 1; d <= dest_count(); d++)
        begin
            best      = (d == self_id) ? 25'd0 : {1'b0, INF_DIST};
            best_port = '0;
            if (d != self_id)
            begin
                for (int p = 1; p <= MAX_PORTS; p++)
                begin
                    nb = port_nbr[p];
                    if (nb == 0 || nb > MAX_ROUTERS)
                        continue;
                    sum = {1'b0, port_cost[p]} + {1'b0, nbr_dist[nb][d]};
                    if (sum < best)
                    begin
                        best      = sum;
                        best_port = p[4:0];
                    end
                end
            end
            if (own_dist[d] != best[23:0] || route_port[d] != best_port)
                changed = 1'b1;
            own_dist[d]   = best[23:0];
            route_port[d] = best_port;
        end
        return changed;
    endfunction

    function automatic void queue_vector();
        int      n;
        advert_t a;
        n = dest_count();
        if (n > OUT_MAX)
            n = OUT_MAX;
        for (int i = 1; i <= n; i++)
        begin
            a.status       = 1'b0;
            a.dest_res     = i[4:0];
            a.own_distance = own_dist[i];
            a.hop_router   = (route_port[i] >= 1 && route_port[i] <= MAX_PORTS) ?
                             port_nbr[route_port[i]] : 5'd0;
            a.last_res     = (i == n);
            adverts_due.push_back(a);
        end
    endfunction

    function automatic void queue_reject();
        advert_t a;
        a.status       = 1'b1;
        a.dest_res     = '0;
        a.own_distance = '0;
        a.hop_router   = '0;
        a.last_res     = 1'b1;
        adverts_due.push_back(a);
    endfunction

    function automatic void route_message();
        logic [23:0] dist_val;
        bit          port_ok;
        bit          refused;
        port_ok  = req.port >= 1 && req.port <= MAX_PORTS;
        refused  = !port_ok || port_cost[req.port] == 0;
        dist_val = (req.distance > INF_DIST) ? INF_DIST : req.distance;
        case (req.func)
            FUNC_ENTRY:
            begin
                if (refused)
                    queue_reject();
                else
                begin
                    if (req.from_router >= 1 && req.from_router <= MAX_ROUTERS)
                    begin
                        if (port_nbr[req.port] == 0)
                            port_nbr[req.port] = req.from_router;
                        // poison reverse: routes through us count as unreachable
                        if (req.dest >= 1 && req.dest <= MAX_ROUTERS)
                            nbr_dist[req.from_router][req.dest] =
                                (req.via_router == self_id) ? INF_DIST : dist_val;
                    end
                    if (req.last && update_routes())
                        queue_vector();
                end
            end
            FUNC_REQUEST:
            begin
                if (refused)
                    queue_reject();
                else
                    queue_vector();
            end
            FUNC_COST:
            begin
                if (port_ok)
                begin
                    port_cost[req.port] = dist_val;
                    void'(update_routes());
                    queue_vector();
                end
            end
            FUNC_DOWN:
            begin
                if (port_ok)
                begin
                    port_cost[req.port] = INF_DIST;
                    port_nbr[req.port]  = '0;
                    void'(update_routes());
                    queue_vector();
                end
            end
            FUNC_TRIGGER:
                queue_vector();
            default:
                ;
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tables();
            adverts_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            advert_t a;
            if (rsp.valid && rsp.ready)
            begin
                if (adverts_due.size() == 0)
                begin
                    $error("response transaction with no entry expected");
                    fail_count++;
                end
                else
                begin
                    a = adverts_due.pop_front();
                    check_field("status", a.status, rsp.status);
                    check_field("dest_res", a.dest_res, rsp.dest_res);
                    check_field("own_distance", a.own_distance, rsp.own_distance);
                    check_field("hop_router", a.hop_router, rsp.hop_router);
                    check_field("last_res", a.last_res, rsp.last_res);
                end
            end
            if (req.valid && req.ready)
                route_message();
            if (cfg_we)
            begin
                if (cfg_idx == REG_SELF_ID)
                    self_id = cfg_data;
                else
                    active_routers = cfg_data;
            end
            pending = adverts_due.size();
        end
    end

endmodule

FILE: tb/distance_vector_route_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_vector_route_engine_test
// Drives route messages and register writes into the route engine: a directed
// pass over the corner cases, then random neighbor vectors, cost changes,
// port downs, requests and noise under several register settings and
// handshake idling patterns. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module distance_vector_route_engine_test;
    import dvr_pkg::*;

    localparam int          LIMIT      = 2000000;
    localparam int          DRAIN_WAIT = 400;
    localparam logic [2:0]  FUNC_SPARE = 3'd5;
    localparam logic [4:0]  NUM_PORTS  = 5'd16;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [0:0] cfg_idx;
    logic [4:0] cfg_data;
    int         fail_count;
    int         pending;
    int         send_idle = 26;
    int         recv_idle = 58;
    int         msg_count = 0;
    int         cycles = 0;

    dvr_req_if req_ch();
    dvr_rsp_if rsp_ch();

    distance_vector_route_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    dvr_route_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    initial rsp_ch.ready = 1'b0;

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_msg(input logic [2:0] func, input logic [4:0] port,
                            input logic [4:0] from, input logic [4:0] dest,
                            input logic [23:0] dist_val, input logic [4:0] via,
                            input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= func;
        req_ch.port        <= port;
        req_ch.from_router <= from;
        req_ch.dest        <= dest;
        req_ch.distance    <= dist_val;
        req_ch.via_router  <= via;
        req_ch.last        <= last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (func <= FUNC_TRIGGER)
            msg_count++;
    endtask

    // Drop valid, wait out every expected entry and any silent recompute.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || !req_ch.ready)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [4:0] value);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [23:0] pick_dist();
        case ($urandom_range(9))
            0:       return 24'd0;
            6:       return INF_DIST;
            7:       return 24'($urandom_range(32'hFFFFFF, INF_DIST + 1));
            8, 9:    return 24'($urandom);
            default: return 24'($urandom_range(20, 1));
        endcase
    endfunction

    function automatic logic [4:0] pick_port();
        return ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(NUM_PORTS, 1));
    endfunction

    task automatic send_vector(input logic [4:0] self_id);
        logic [4:0] port;
        logic [4:0] from;
        int         count;
        bit         scattered;
        port      = 5'($urandom_range(NUM_PORTS, 1));
        from      = 5'($urandom_range(16, 1));
        count     = $urandom_range(16, 1);
        scattered = ($urandom_range(4) == 0);
        for (int i = 1; i <= count; i++)
            send_msg(FUNC_ENTRY, port, from,
                     scattered ? 5'($urandom) : 5'(i), pick_dist(),
                     ($urandom_range(4) == 0) ? self_id : 5'($urandom_range(16)),
                     i == count);
    endtask

    task automatic random_msg(input logic [4:0] self_id);
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            send_vector(self_id);
        else if (pick < 62)
            send_msg(FUNC_COST, pick_port(), 5'($urandom), 5'($urandom),
                     ($urandom_range(7) == 0) ? 24'd0 : pick_dist(), 5'($urandom), 1'($urandom));
        else if (pick < 70)
            send_msg(FUNC_DOWN, pick_port(), 5'($urandom), 5'($urandom),
                     24'($urandom), 5'($urandom), 1'($urandom));
        else if (pick < 78)
            send_msg(FUNC_REQUEST, pick_port(), 5'($urandom), 5'($urandom),
                     24'($urandom), 5'($urandom), 1'($urandom));
        else if (pick < 84)
            send_msg(FUNC_TRIGGER, 5'($urandom), 5'($urandom), 5'($urandom),
                     24'($urandom), 5'($urandom), 1'($urandom));
        else
            send_msg(3'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                     24'($urandom), 5'($urandom), 1'($urandom));
    endtask

    initial
    begin
        logic [4:0] self_ids [6];
        logic [4:0] actives  [6];
        int         phase_start;
        self_ids = '{5'd3, 5'd16, 5'd1, 5'd31, 5'd0, 5'd7};
        actives  = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd12};
        req_ch.valid       <= 1'b0;
        req_ch.func        <= FUNC_ENTRY;
        req_ch.port        <= '0;
        req_ch.from_router <= '0;
        req_ch.dest        <= '0;
        req_ch.distance    <= '0;
        req_ch.via_router  <= '0;
        req_ch.last        <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= REG_SELF_ID;
        cfg_data           <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed corner cases, starting from the reset settings
        send_msg(FUNC_REQUEST, 5'd1, 5'd0, 5'd0, 24'd0, 5'd0, 1'b0);
        send_msg(FUNC_COST, 5'd1, 5'd0, 5'd0, 24'd5, 5'd0, 1'b0);
        send_msg(FUNC_COST, 5'd2, 5'd0, 5'd0, 24'd0, 5'd0, 1'b0);
        send_msg(FUNC_COST, 5'd16, 5'd0, 5'd0, 24'hFFFFFF, 5'd0, 1'b0);
        send_msg(FUNC_ENTRY, 5'd1, 5'd2, 5'd3, 24'd7, 5'd0, 1'b0);
        send_msg(FUNC_ENTRY, 5'd1, 5'd2, 5'd1, 24'd0, 5'd1, 1'b0);
        send_msg(FUNC_ENTRY, 5'd1, 5'd2, 5'd16, 24'hFFFFFF, 5'd16, 1'b1);
        send_msg(FUNC_ENTRY, 5'd2, 5'd4, 5'd3, 24'd1, 5'd0, 1'b1);
        send_msg(FUNC_REQUEST, 5'd2, 5'd0, 5'd0, 24'd0, 5'd0, 1'b0);
        send_msg(FUNC_ENTRY, 5'd0, 5'd3, 5'd3, 24'd1, 5'd0, 1'b1);
        send_msg(FUNC_ENTRY, 5'd31, 5'd3, 5'd3, 24'd1, 5'd0, 1'b1);
        send_msg(FUNC_REQUEST, 5'd17, 5'd0, 5'd0, 24'd0, 5'd0, 1'b0);
        send_msg(FUNC_ENTRY, 5'd16, 5'd0, 5'd5, 24'd1, 5'd0, 1'b1);
        send_msg(FUNC_ENTRY, 5'd16, 5'd31, 5'd5, 24'd1, 5'd0, 1'b1);
        send_msg(FUNC_ENTRY, 5'd16, 5'd9, 5'd0, 24'd2, 5'd0, 1'b0);
        send_msg(FUNC_ENTRY, 5'd16, 5'd9, 5'd31, 24'd2, 5'd0, 1'b1);
        send_msg(FUNC_COST, 5'd0, 5'd0, 5'd0, 24'd3, 5'd0, 1'b0);
        send_msg(FUNC_DOWN, 5'd20, 5'd0, 5'd0, 24'd0, 5'd0, 1'b0);
        send_msg(FUNC_SPARE, 5'd1, 5'd2, 5'd3, 24'd4, 5'd0, 1'b1);
        send_msg(FUNC_SPARE + 3'd2, 5'd1, 5'd2, 5'd3, 24'd4, 5'd0, 1'b1);
        send_msg(FUNC_TRIGGER, 5'd0, 5'd0, 5'd0, 24'd0, 5'd0, 1'b0);
        send_msg(FUNC_DOWN, 5'd1, 5'd0, 5'd0, 24'd0, 5'd0, 1'b0);
        write_reg(REG_ACTIVE_ROUTERS, 5'd0);
        send_msg(FUNC_TRIGGER, 5'd1, 5'd0, 5'd0, 24'd0, 5'd0, 1'b0);
        write_reg(REG_SELF_ID, 5'd31);
        write_reg(REG_ACTIVE_ROUTERS, 5'd31);
        send_msg(FUNC_COST, 5'd3, 5'd0, 5'd0, 24'd2, 5'd0, 1'b0);

        // random phases, each with its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle = 58;
                recv_idle = 26;
            end
            else if (ph == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(REG_SELF_ID, self_ids[ph]);
            write_reg(REG_ACTIVE_ROUTERS, actives[ph]);
            phase_start = msg_count;
            while (msg_count - phase_start < 52)
                random_msg(self_ids[ph]);
        end

        settle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
